// ===== hdl/cel_pkg.sv =====
`timescale 1ns / 1ps

package cel_pkg;

	// fixed field widths
	localparam int unsigned IndexW     = 12;
	localparam int unsigned RowStartW  = 13;
	localparam int unsigned ColumnW    = 16;
	localparam int unsigned ValueW     = 64;
	localparam int unsigned RowCountW  = 9;

	// rows shorter than this are scanned, the rest binary-searched
	localparam int unsigned LinearLimit = 16;

	typedef enum logic [1:0] {
		OP_ROW_START = 2'd0,
		OP_ENTRY     = 2'd1,
		OP_LOOKUP    = 2'd2
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [IndexW-1:0]    index;
		logic [RowStartW-1:0] row_start;
		logic [ColumnW-1:0]   column;
		logic [ValueW-1:0]    entry_value;
	} in_item_t;

	typedef struct packed {
		logic              found;
		logic [ValueW-1:0] element_value;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW_LO,
		ST_ROW_HI,
		ST_BOUNDS,
		ST_LINEAR,
		ST_BINARY,
		ST_FINAL_CHK,
		ST_RESP
	} lk_state_t;

endpackage

// ===== hdl/cel_sram.sv =====
`timescale 1ns / 1ps

module cel_sram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/cel_ctrl.sv =====
`timescale 1ns / 1ps

module cel_ctrl #(
	parameter int unsigned MAX_ROWS    = 256,
	parameter int unsigned MAX_ENTRIES = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  cel_pkg::in_item_t                 in_data,
	input  logic [cel_pkg::RowCountW-1:0]     row_count,
	output logic                              res_valid,
	input  logic                              res_ready,
	output cel_pkg::out_item_t                res
);

	localparam int unsigned RA_W  = $clog2(MAX_ROWS + 1);
	localparam int unsigned EA_W  = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned POS_W = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned EW    = cel_pkg::ColumnW + cel_pkg::ValueW;

	cel_pkg::lk_state_t state_q, state_d;

	// row-start memory port
	logic                          rs_we, rs_re;
	logic [RA_W-1:0]               rs_raddr;
	logic [cel_pkg::RowStartW-1:0] rs_rdata;

	// entry memory port, column above value
	logic                          en_we, en_re;
	logic [EA_W-1:0]               en_raddr;
	logic [EW-1:0]                 en_rdata;
	logic [cel_pkg::ColumnW-1:0]   en_col;
	logic [cel_pkg::ValueW-1:0]    en_val;

	logic [31:0]                   idx_ext;
	logic                          rs_ok, en_ok, row_ok;
	logic [31:0]                   rs_ext, rs_clamped;
	logic [POS_W-1:0]              rs_pos, span;

	logic [RA_W-1:0]               row_q;
	logic [cel_pkg::ColumnW-1:0]   col_q;
	logic [POS_W-1:0]              lo_q, hi_q, k_q, s_q, e_q, mid_q;
	logic                          pend_q;
	logic                          found_q;
	logic [cel_pkg::ValueW-1:0]    value_q;

	logic                          lin_hit;
	logic [POS_W-1:0]              s_n, e_n, diff_n, mid_n;

	assign idx_ext = 32'(in_data.index);
	assign rs_ok   = idx_ext <= MAX_ROWS;
	assign en_ok   = idx_ext < MAX_ENTRIES;
	assign row_ok  = (idx_ext < 32'(row_count)) && (idx_ext < MAX_ROWS);

	// row bounds clamped to the end of the entry store
	assign rs_ext     = 32'(rs_rdata);
	assign rs_clamped = (rs_ext > MAX_ENTRIES) ? 32'(MAX_ENTRIES) : rs_ext;
	assign rs_pos     = rs_clamped[POS_W-1:0];
	assign span       = rs_pos - lo_q;

	assign en_col  = en_rdata[EW-1:cel_pkg::ValueW];
	assign en_val  = en_rdata[cel_pkg::ValueW-1:0];
	assign lin_hit = pend_q && (en_col == col_q);

	// next search window from the probe that just returned
	always_comb begin
		s_n = s_q;
		e_n = e_q;
		if (pend_q) begin
			if (en_col < col_q) begin
				s_n = mid_q + POS_W'(1);
			end else begin
				e_n = mid_q;
			end
		end
		diff_n = e_n - s_n;
		mid_n  = s_n + (diff_n >> 1);
	end

	cel_sram #(
		.DEPTH(MAX_ROWS + 1),
		.WIDTH(cel_pkg::RowStartW)
	) u_row_mem (
		.clk  (clk),
		.we   (rs_we),
		.waddr(idx_ext[RA_W-1:0]),
		.wdata(in_data.row_start),
		.re   (rs_re),
		.raddr(rs_raddr),
		.rdata(rs_rdata)
	);

	cel_sram #(
		.DEPTH(MAX_ENTRIES),
		.WIDTH(EW)
	) u_entry_mem (
		.clk  (clk),
		.we   (en_we),
		.waddr(idx_ext[EA_W-1:0]),
		.wdata({in_data.column, in_data.entry_value}),
		.re   (en_re),
		.raddr(en_raddr),
		.rdata(en_rdata)
	);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		rs_we     = 1'b0;
		rs_re     = 1'b0;
		rs_raddr  = row_q;
		en_we     = 1'b0;
		en_re     = 1'b0;
		en_raddr  = k_q[EA_W-1:0];
		res_valid = 1'b0;
		unique case (state_q)
			cel_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_data.op)
						cel_pkg::OP_ROW_START: rs_we = rs_ok;
						cel_pkg::OP_ENTRY:     en_we = en_ok;
						cel_pkg::OP_LOOKUP: begin
							state_d = row_ok ? cel_pkg::ST_ROW_LO : cel_pkg::ST_RESP;
						end
						default: ;
					endcase
				end
			end
			cel_pkg::ST_ROW_LO: begin
				rs_re   = 1'b1;
				state_d = cel_pkg::ST_ROW_HI;
			end
			cel_pkg::ST_ROW_HI: begin
				rs_re    = 1'b1;
				rs_raddr = row_q + RA_W'(1);
				state_d  = cel_pkg::ST_BOUNDS;
			end
			cel_pkg::ST_BOUNDS: begin
				if (rs_pos <= lo_q) begin
					state_d = cel_pkg::ST_RESP;
				end else if (32'(span) < cel_pkg::LinearLimit) begin
					state_d = cel_pkg::ST_LINEAR;
				end else begin
					state_d = cel_pkg::ST_BINARY;
				end
			end
			cel_pkg::ST_LINEAR: begin
				if (lin_hit || (k_q == hi_q)) begin
					state_d = cel_pkg::ST_RESP;
				end else begin
					en_re    = 1'b1;
					en_raddr = k_q[EA_W-1:0];
				end
			end
			cel_pkg::ST_BINARY: begin
				if (s_n < e_n) begin
					en_re    = 1'b1;
					en_raddr = mid_n[EA_W-1:0];
				end else if (s_n < hi_q) begin
					en_re    = 1'b1;
					en_raddr = s_n[EA_W-1:0];
					state_d  = cel_pkg::ST_FINAL_CHK;
				end else begin
					state_d = cel_pkg::ST_RESP;
				end
			end
			cel_pkg::ST_FINAL_CHK: begin
				state_d = cel_pkg::ST_RESP;
			end
			cel_pkg::ST_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = cel_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cel_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cel_pkg::ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= en_re && (state_d == state_q);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cel_pkg::ST_IDLE: begin
				if (in_valid && (in_data.op == cel_pkg::OP_LOOKUP)) begin
					row_q   <= idx_ext[RA_W-1:0];
					col_q   <= in_data.column;
					found_q <= 1'b0;
					value_q <= '0;
				end
			end
			cel_pkg::ST_ROW_HI: begin
				lo_q <= rs_pos;
			end
			cel_pkg::ST_BOUNDS: begin
				hi_q <= rs_pos;
				k_q  <= lo_q;
				s_q  <= lo_q;
				e_q  <= rs_pos;
			end
			cel_pkg::ST_LINEAR: begin
				if (lin_hit) begin
					found_q <= 1'b1;
					value_q <= en_val;
				end else if (k_q != hi_q) begin
					k_q <= k_q + POS_W'(1);
				end
			end
			cel_pkg::ST_BINARY: begin
				s_q   <= s_n;
				e_q   <= e_n;
				mid_q <= mid_n;
			end
			cel_pkg::ST_FINAL_CHK: begin
				if (en_col == col_q) begin
					found_q <= 1'b1;
					value_q <= en_val;
				end
			end
			default: ;
		endcase
	end

	assign res = '{found: found_q, element_value: value_q};

`ifndef SYNTHESIS
	// a lookup holds off further beats while it runs
	a_lookup_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_data.op == cel_pkg::OP_LOOKUP)) |=> !in_ready)
		else $error("input taken during a running lookup");

	// table writes only between lookups, so reads never race a write
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rs_we || en_we) |-> (state_q == cel_pkg::ST_IDLE))
		else $error("table write during a lookup");

	// the linear scan never reads past the row end
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(en_re && (state_q == cel_pkg::ST_LINEAR)) |-> (k_q < hi_q))
		else $error("scan read beyond row end");

	// binary window stays ordered and inside the row
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cel_pkg::ST_BINARY) |-> ((s_q <= e_q) && (e_q <= hi_q) && (lo_q <= s_q)))
		else $error("binary search window out of the row");
`endif

endmodule

// ===== hdl/csr_element_lookup.sv =====
`timescale 1ns / 1ps

// Element lookup in a sparse matrix held in compressed-row form. Input beats with
// op OP_ROW_START write one row-start word, beats with OP_ENTRY write one column and
// 64-bit value; neither gives an output beat. An OP_LOOKUP beat returns one output
// beat with found and the stored value bits, or zero with found clear. The row-start
// table and the column/value store are synchronous memories with one read and one
// write port and no reset: load every entry a lookup can touch before querying.
// A write leaves the block idle and ready for the next beat. A lookup is handled
// one at a time: a row outside row_count goes straight to the result. Otherwise two
// row-start reads and a bounds check come first, and an empty or reversed row ends
// there; then either a linear scan of a short row (one entry memory read per cycle
// plus a closing check) or a binary search of a long row (one probe per cycle, then
// a read of the lowest candidate and a final check), and the result is handed over.
// The output register lets the next input beat be taken while a result still waits.
module csr_element_lookup #(
	parameter int unsigned MAX_ROWS    = 256,
	parameter int unsigned MAX_ENTRIES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// item channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cel_pkg::in_item_t             in_data,

	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output cel_pkg::out_item_t            out_data,

	// row_count register write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cel_pkg::RowCountW-1:0] cfg_data
);

	// number of rows in use, zero after reset
	logic [cel_pkg::RowCountW-1:0] row_count_q;

	// result handoff from the search sequencer
	logic                          res_valid;
	logic                          res_ready;
	cel_pkg::out_item_t            res;

	// output register
	logic                          out_valid_q;
	cel_pkg::out_item_t            out_q;

	// register writes are always taken, one per beat
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
		end else if (cfg_valid) begin
			row_count_q <= cfg_data;
		end
	end

	cel_ctrl #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.row_count(row_count_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// the slot frees up when the held beat leaves in the same cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== dv/tb_csr_element_lookup.sv =====
`timescale 1ns / 1ps

module tb_csr_element_lookup;

	localparam int unsigned IndexW      = cel_pkg::IndexW;
	localparam int unsigned RowStartW   = cel_pkg::RowStartW;
	localparam int unsigned ColumnW     = cel_pkg::ColumnW;
	localparam int unsigned ValueW      = cel_pkg::ValueW;
	localparam int unsigned RowCountW   = cel_pkg::RowCountW;
	localparam int unsigned LinearLimit = cel_pkg::LinearLimit;

	localparam int unsigned MaxRows    = 256;
	localparam int unsigned MaxEntries = 4096;
	// random layouts go on until this many input beats have been sent in all
	localparam int          TotalBeats = 1950;
	// long receiver hold-off, counted by the result sink itself
	localparam int          HoldCycles  = 500;
	// quiet cycles after the last result before touching row_count or ending
	localparam int          SettleCycles = 40;

	// op code with no meaning for the block, must be dropped silently
	localparam cel_pkg::op_t OpUnused = cel_pkg::op_t'(2'd3);

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_MOSTLY,
		SINK_PERIODIC
	} sink_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	cel_pkg::in_item_t    in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	cel_pkg::out_item_t   out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [RowCountW-1:0] cfg_data = '0;

	csr_element_lookup #(
		.MAX_ROWS    (MaxRows),
		.MAX_ENTRIES (MaxEntries)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// shadow copy of the matrix and the row_count register
	logic [RowCountW-1:0] sh_row_count = '0;
	logic [RowStartW-1:0] sh_row_start [0:MaxRows];
	logic [ColumnW-1:0]   sh_col [0:MaxEntries-1];
	logic [ValueW-1:0]    sh_val [0:MaxEntries-1];

	// lookups accepted but not yet answered, oldest first
	cel_pkg::out_item_t pending_elements [$];

	int mismatches      = 0;
	int counted_items   = 0;
	int burst_left      = 0;
	int holds_requested = 0;

	// layout of the matrix loaded last: rows 0 .. rows_in_use-1
	int rows_in_use = 0;
	int row_first [0:MaxRows];
	int row_len   [0:MaxRows];

	// element (row, col) as the block must return it
	function automatic cel_pkg::out_item_t lookup_element(input logic [IndexW-1:0] row,
			input logic [ColumnW-1:0] col);
		cel_pkg::out_item_t r;
		int unsigned        lo, hi, s, e, mid;
		r = '0;
		if (row >= sh_row_count || row >= MaxRows)
			return r;
		lo = 32'(sh_row_start[row]);
		hi = 32'(sh_row_start[int'(row) + 1]);
		// bounds past the stores are clamped to the store size
		if (lo > MaxEntries)
			lo = MaxEntries;
		if (hi > MaxEntries)
			hi = MaxEntries;
		// empty or reversed row
		if (hi <= lo)
			return r;
		if (hi - lo < LinearLimit) begin
			// short row: linear scan, first match wins
			for (int unsigned k = lo; k < hi; k++) begin
				if (sh_col[k] == col) begin
					r.found = 1'b1;
					r.element_value = sh_val[k];
					return r;
				end
			end
			return r;
		end
		// long row: lowest position whose column is not below the query
		s = lo;
		e = hi;
		while (s < e) begin
			mid = s + (e - s) / 2;
			if (sh_col[mid] < col)
				s = mid + 1;
			else
				e = mid;
		end
		if (s < hi && sh_col[s] == col) begin
			r.found = 1'b1;
			r.element_value = sh_val[s];
		end
		return r;
	endfunction

	// fold one accepted input beat into the shadow state
	function automatic void shadow_apply(input cel_pkg::in_item_t it);
		case (it.op)
			cel_pkg::OP_ROW_START: begin
				if (it.index <= MaxRows)
					sh_row_start[it.index] = it.row_start;
			end
			cel_pkg::OP_ENTRY: begin
				sh_col[it.index] = it.column;
				sh_val[it.index] = it.entry_value;
			end
			cel_pkg::OP_LOOKUP:
				pending_elements.push_back(lookup_element(it.index, it.column));
			default: ;
		endcase
	endfunction

	// every field random, op defaults to a lookup
	function automatic cel_pkg::in_item_t rand_item();
		cel_pkg::in_item_t it;
		it.op          = cel_pkg::OP_LOOKUP;
		it.index       = IndexW'($urandom);
		it.row_start   = RowStartW'($urandom);
		it.column      = ColumnW'($urandom);
		it.entry_value = {$urandom, $urandom};
		return it;
	endfunction

	function automatic logic [ValueW-1:0] rand_value();
		int x;
		x = $urandom_range(0, 15);
		if (x == 0)
			return '0;
		if (x == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// one input beat; the sender runs in bursts with random gaps in between
	task automatic send_item(input cel_pkg::in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 :
				($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 50);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		shadow_apply(it);
		counted_items++;
	endtask

	// beats the block has to drop: unused op or a row-start slot past the table
	task automatic send_ignored();
		cel_pkg::in_item_t it;
		it = rand_item();
		if ($urandom_range(0, 1) == 0) begin
			it.op = OpUnused;
		end else begin
			it.op    = cel_pkg::OP_ROW_START;
			it.index = IndexW'($urandom_range(MaxRows + 1, (1 << IndexW) - 1));
		end
		send_item(it);
	endtask

	// stop sending and let every lookup come back, plus a margin for trailing writes
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_elements.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_row_count(input int n);
		drain_block();
		cfg_valid <= 1'b1;
		cfg_data  <= RowCountW'(n);
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		sh_row_count = RowCountW'(n);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_lookup(input int row, input int col);
		cel_pkg::in_item_t it;
		it = rand_item();
		it.op     = cel_pkg::OP_LOOKUP;
		it.index  = IndexW'(row);
		it.column = ColumnW'(col);
		send_item(it);
	endtask

	task automatic send_entry(input int pos, input int col, input logic [ValueW-1:0] v);
		cel_pkg::in_item_t it;
		it = rand_item();
		it.op          = cel_pkg::OP_ENTRY;
		it.index       = IndexW'(pos);
		it.column      = ColumnW'(col);
		it.entry_value = v;
		send_item(it);
	endtask

	task automatic send_row_start(input int slot, input int start);
		cel_pkg::in_item_t it;
		it = rand_item();
		it.op        = cel_pkg::OP_ROW_START;
		it.index     = IndexW'(slot);
		it.row_start = RowStartW'(start);
		send_item(it);
	endtask

	// build a fresh matrix of n rows: row-start table 0..n, then every entry the rows own
	// flush_top packs the entries against the top of the store and ends the last row
	// with a row-start word at or past the store end, which the clamp brings back to the end
	task automatic load_layout(input int n, input bit flush_top);
		int total, pos, c, len, x;
		bit ascending;
		total = 0;
		for (int r = 0; r < n; r++) begin
			x = $urandom_range(0, 99);
			if (total >= 480)
				len = 0;
			else if (n > 64)
				len = (x < 80) ? 0 : (x < 95) ? $urandom_range(1, 15) : $urandom_range(16, 40);
			else
				len = (x < 10) ? 0 : (x < 75) ? $urandom_range(1, 15) : $urandom_range(16, 48);
			row_len[r] = len;
			total += len;
		end
		pos = flush_top ? MaxEntries - total : $urandom_range(0, MaxEntries - total);
		for (int r = 0; r < n; r++) begin
			row_first[r] = pos;
			pos += row_len[r];
		end
		rows_in_use = n;

		for (int r = 0; r <= n; r++) begin
			if (r < n)
				send_row_start(r, row_first[r]);
			else if (flush_top)
				send_row_start(r, $urandom_range(MaxEntries, (1 << RowStartW) - 1));
			else
				send_row_start(r, pos);
			if ($urandom_range(0, 19) == 0)
				send_ignored();
		end

		for (int r = 0; r < n; r++) begin
			// long rows mostly sorted for the binary search, now and then not
			ascending = row_len[r] >= LinearLimit && $urandom_range(0, 9) != 0;
			if (ascending)
				c = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 64000);
			else
				c = $urandom_range(0, 65528);
			for (int k = 0; k < row_len[r]; k++) begin
				if (ascending) begin
					// small steps, zero step gives duplicate columns
					if (k > 0)
						c += $urandom_range(0, 3);
					if (c > 65535)
						c = 65535;
					send_entry(row_first[r] + k, c, rand_value());
				end else begin
					// narrow column window so short rows get repeats
					x = $urandom_range(0, 19);
					send_entry(row_first[r] + k,
						(x == 0) ? 0 : (x == 1) ? 65535 : c + $urandom_range(0, 7),
						rand_value());
				end
				if ($urandom_range(0, 29) == 0)
					send_ignored();
			end
		end
	endtask

	// lookups on the loaded matrix, mixed with value rewrites and dropped beats
	task automatic lookup_mix(input int m);
		int x, r, pos, col;
		for (int i = 0; i < m; i++) begin
			x = $urandom_range(0, 99);
			r = (rows_in_use > 0) ? $urandom_range(0, rows_in_use - 1) : 0;
			// prefer rows that hold something
			for (int t = 0; t < 4 && rows_in_use > 0 && row_len[r] == 0; t++)
				r = $urandom_range(0, rows_in_use - 1);
			if (x < 8 && rows_in_use > 0 && row_len[r] > 0) begin
				// new value, same column, so a sorted row stays sorted
				pos = row_first[r] + $urandom_range(0, row_len[r] - 1);
				send_entry(pos, int'(sh_col[pos]), rand_value());
			end else if (x < 22) begin
				send_lookup($urandom_range(rows_in_use, (1 << IndexW) - 1), $urandom);
			end else if (x < 25) begin
				send_ignored();
			end else if (rows_in_use > 0) begin
				if (row_len[r] > 0 && $urandom_range(0, 9) < 7) begin
					col = int'(sh_col[row_first[r] + $urandom_range(0, row_len[r] - 1)]);
				end else if (row_len[r] > 0) begin
					// near miss around the row's first column
					col = (sh_col[row_first[r]] + $urandom_range(0, 9) - 4) & 16'hffff;
				end else begin
					col = $urandom;
				end
				send_lookup(r, col);
			end else begin
				send_lookup($urandom, $urandom);
			end
		end
	endtask

	// row_count comes out of reset as zero, so any row is out of range
	task automatic test_reset_row_count();
		send_lookup(0, 0);
	endtask

	// hand-built matrix hitting the corners:
	//   row 0: [4093, 8191) -> end clamped to the store, duplicate column
	//   row 1: both bounds past the store -> empty after clamping
	//   row 2: reversed bounds -> empty
	//   row 3: [0, 2) with a stored zero value and column 65535
	task automatic test_directed_corners();
		logic [ValueW-1:0] va, vb, vc;
		cel_pkg::in_item_t it;
		va = {$urandom, $urandom};
		vb = ~va;
		vc = {$urandom, $urandom};
		write_row_count(4);
		send_row_start(0, 4093);
		send_row_start(1, (1 << RowStartW) - 1);
		send_row_start(2, 4100);
		send_row_start(3, 0);
		send_row_start(4, 2);
		send_entry(4093, 7, va);
		send_entry(4094, 7, vb);
		send_entry(4095, 65535, vc);
		send_entry(0, 0, '0);
		send_entry(1, 65535, '1);
		// slot past the table; a block that wraps the index would clobber row 3
		send_row_start(MaxRows + 3, (1 << RowStartW) - 1);
		it = rand_item();
		it.op = OpUnused;
		send_item(it);
		send_lookup(0, 7);
		send_lookup(0, 65535);
		send_lookup(0, 3);
		send_lookup(1, 0);
		send_lookup(2, 0);
		send_lookup(3, 0);
		send_lookup(3, 65535);
		send_lookup(4, 0);
		send_lookup((1 << IndexW) - 1, 65535);
	endtask

	// result sink stops for a long stretch while lookups keep coming
	task automatic test_output_backpressure();
		write_row_count(8);
		load_layout(8, 1'b0);
		holds_requested++;
		lookup_mix(40);
	endtask

	// random matrices under several row_count settings, extremes first
	task automatic test_random_layouts();
		int phase, n;
		phase = 0;
		while (counted_items < TotalBeats) begin
			case (phase)
				0: n = MaxRows;
				1: n = 0;
				2: n = 1;
				default: n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MaxRows) :
					$urandom_range(2, 40);
			endcase
			write_row_count(n);
			load_layout(n, $urandom_range(0, 4) == 0);
			lookup_mix($urandom_range(20, 90));
			phase++;
		end
	endtask

	// result sink: own stall pattern, switching mode now and then,
	// plus the long hold-off when a test asks for it
	initial begin : result_sink
		sink_mode_t mode;
		int mode_left, hold_left, holds_served, tick;
		mode = SINK_OPEN;
		mode_left = 0;
		hold_left = 0;
		holds_served = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (holds_served != holds_requested) begin
				holds_served = holds_requested;
				hold_left = HoldCycles;
			end
			if (mode_left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					SINK_OPEN:   out_ready <= 1'b1;
					SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
					SINK_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
					default:     out_ready <= (tick % 7) < 3;
				endcase
			end
		end
	end

	// compare every result beat with the oldest pending lookup
	always @(posedge clk) begin
		cel_pkg::out_item_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_elements.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with no lookup pending, expected none,",
					$time);
				$display("%0t:   actual found %0b value %h",
					$time, out_data.found, out_data.element_value);
			end else begin
				want = pending_elements.pop_front();
				if (out_data.found !== want.found) begin
					mismatches++;
					$display("%0t: found wrong, expected %0b, actual %0b",
						$time, want.found, out_data.found);
				end
				if (out_data.element_value !== want.element_value) begin
					mismatches++;
					$display("%0t: element_value wrong, expected %h, actual %h",
						$time, want.element_value, out_data.element_value);
				end
			end
		end
	end

	// hard stop well past the slowest legal run
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_row_count();
		test_directed_corners();
		test_output_backpressure();
		test_random_layouts();

		drain_block();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/cel_pkg.sv
hdl/cel_sram.sv
hdl/cel_ctrl.sv
hdl/csr_element_lookup.sv
dv/tb_csr_element_lookup.sv
